[rtl/core/ocp_pkg.sv]
package ocp_pkg;

	// Field widths fixed by the tour format
	localparam int CITY_W = 6;
	localparam int CUT_W  = 5;
	localparam int CC_W   = 6;

	localparam logic [CC_W-1:0] CC_RESET = 6'd32;

endpackage

[rtl/core/ocp_if.sv]
interface ocp_in_if;
	import ocp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CITY_W-1:0] mother_city;
	logic [CITY_W-1:0] father_city;
	logic [CUT_W-1:0]  cut_point;

	modport source (output valid, output mother_city, output father_city, output cut_point,
		input ready);
	modport sink (input valid, input mother_city, input father_city, input cut_point,
		output ready);
endinterface

interface ocp_out_if;
	import ocp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CITY_W-1:0] child_one_city;
	logic [CITY_W-1:0] child_two_city;
	logic              last_position;

	modport source (output valid, output child_one_city, output child_two_city,
		output last_position, input ready);
	modport sink (input valid, input child_one_city, input child_two_city,
		input last_position, output ready);
endinterface

[rtl/core/ocp_front.sv]
module ocp_front #(
	parameter int MAX_CITIES = 32,
	localparam int AW = $clog2(MAX_CITIES),
	localparam int CW = $clog2(MAX_CITIES + 1),
	localparam int JOB_W = 1 + 2 * CW + 2 * MAX_CITIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ocp_in_if.sink                    parents,
	input  logic                      cfg_wr_en,
	input  logic [ocp_pkg::CC_W-1:0]  cfg_wr_data,
	output logic                      par_we,
	output logic                      par_bank,
	output logic [AW-1:0]             par_idx,
	output logic [ocp_pkg::CITY_W-1:0] par_mother,
	output logic [ocp_pkg::CITY_W-1:0] par_father,
	output logic                      job_push,
	output logic [JOB_W-1:0]          job_data,
	input  logic                      job_release
);
	import ocp_pkg::*;

	function automatic logic [MAX_CITIES-1:0] city_mask(input logic [CITY_W-1:0] c);
		logic [MAX_CITIES-1:0] m;
		m = '0;
		for (int j = 0; j < MAX_CITIES; j++) begin
			m[j] = (int'(c) == j + 1);
		end
		return m;
	endfunction

	logic [CC_W-1:0]       city_count_q;
	logic [AW-1:0]         pos_q;
	logic [CUT_W-1:0]      held_cut_q;
	logic [MAX_CITIES-1:0] map1_q;
	logic [MAX_CITIES-1:0] map2_q;
	logic                  bank_q;
	logic [1:0]            banks_used_q;

	logic [CW-1:0]         tour_len;
	logic [CUT_W-1:0]      cut_now;
	logic                  accept;
	logic                  in_prefix;
	logic                  last_pos;
	logic [MAX_CITIES-1:0] map1_nxt;
	logic [MAX_CITIES-1:0] map2_nxt;
	logic [CW-1:0]         job_cut;

	// Clamp the register into 2..MAX_CITIES
	always_comb begin
		if (city_count_q < CC_W'(2)) begin
			tour_len = CW'(2);
		end else if (int'(city_count_q) > MAX_CITIES) begin
			tour_len = CW'(MAX_CITIES);
		end else begin
			tour_len = CW'(city_count_q);
		end
	end

	assign parents.ready = (banks_used_q != 2'd2);
	assign accept        = parents.valid && parents.ready;
	assign cut_now       = (pos_q == '0) ? parents.cut_point : held_cut_q;
	assign in_prefix     = int'(pos_q) < int'(cut_now);
	assign map1_nxt      = map1_q | (in_prefix ? city_mask(parents.mother_city) : '0);
	assign map2_nxt      = map2_q | (in_prefix ? city_mask(parents.father_city) : '0);
	assign last_pos      = (CW'(pos_q) + CW'(1)) == tour_len;
	assign job_cut       = (int'(cut_now) < int'(tour_len)) ? CW'(cut_now) : tour_len;

	assign par_we     = accept;
	assign par_bank   = bank_q;
	assign par_idx    = pos_q;
	assign par_mother = parents.mother_city;
	assign par_father = parents.father_city;

	assign job_push = accept && last_pos;
	assign job_data = {bank_q, tour_len, job_cut, map1_nxt, map2_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CC_RESET;
			pos_q        <= '0;
			held_cut_q   <= CUT_W'(1);
			map1_q       <= '0;
			map2_q       <= '0;
			bank_q       <= 1'b0;
		end else if (cfg_wr_en) begin
			city_count_q <= cfg_wr_data;
			pos_q        <= '0;
			map1_q       <= '0;
			map2_q       <= '0;
		end else if (accept) begin
			if (pos_q == '0) begin
				held_cut_q <= parents.cut_point;
			end
			if (last_pos) begin
				pos_q  <= '0;
				map1_q <= '0;
				map2_q <= '0;
				bank_q <= ~bank_q;
			end else begin
				pos_q  <= pos_q + AW'(1);
				map1_q <= map1_nxt;
				map2_q <= map2_nxt;
			end
		end
	end

	// Banks taken by loaded pairs not yet fully emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_used_q <= 2'd0;
		end else begin
			case ({job_push, job_release})
				2'b10:   banks_used_q <= banks_used_q + 2'd1;
				2'b01:   banks_used_q <= banks_used_q - 2'd1;
				default: banks_used_q <= banks_used_q;
			endcase
		end
	end

endmodule

[rtl/core/ocp_job_fifo.sv]
module ocp_job_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import ocp_pkg::*;

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign not_empty = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2 || pop))
		else $error("job queue overflow");

endmodule

[rtl/core/ocp_back.sv]
module ocp_back #(
	parameter int MAX_CITIES = 32,
	localparam int AW = $clog2(MAX_CITIES),
	localparam int CW = $clog2(MAX_CITIES + 1),
	localparam int JOB_W = 1 + 2 * CW + 2 * MAX_CITIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ocp_out_if.source                  children,
	input  logic                       par_we,
	input  logic                       par_bank,
	input  logic [AW-1:0]              par_idx,
	input  logic [ocp_pkg::CITY_W-1:0] par_mother,
	input  logic [ocp_pkg::CITY_W-1:0] par_father,
	input  logic                       job_valid,
	input  logic [JOB_W-1:0]           job_data,
	output logic                       job_pop,
	output logic                       job_release
);
	import ocp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	function automatic logic [MAX_CITIES-1:0] city_mask(input logic [CITY_W-1:0] c);
		logic [MAX_CITIES-1:0] m;
		m = '0;
		for (int j = 0; j < MAX_CITIES; j++) begin
			m[j] = (int'(c) == j + 1);
		end
		return m;
	endfunction

	// Parent stores, two banks; child tails written by the walk
	logic [CITY_W-1:0] mother_mem [2][MAX_CITIES];
	logic [CITY_W-1:0] father_mem [2][MAX_CITIES];
	logic [CITY_W-1:0] tail1_mem [MAX_CITIES];
	logic [CITY_W-1:0] tail2_mem [MAX_CITIES];

	logic [1:0]            state_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         cnt1_q;
	logic [CW-1:0]         cnt2_q;
	logic                  walk_v_s1;
	logic                  walk_last_s1;
	logic                  emit_v_s1;
	logic                  out_v_q;

	logic                  bank_q;
	logic [CW-1:0]         n_q;
	logic [CW-1:0]         cut_q;
	logic [MAX_CITIES-1:0] map1_q;
	logic [MAX_CITIES-1:0] map2_q;
	logic [CITY_W-1:0]     par_m_s1;
	logic [CITY_W-1:0]     par_f_s1;
	logic [CITY_W-1:0]     tail1_s1;
	logic [CITY_W-1:0]     tail2_s1;
	logic                  emit_pre_s1;
	logic                  emit_ok1_s1;
	logic                  emit_ok2_s1;
	logic                  emit_last_s1;
	logic [CITY_W-1:0]     c1_q;
	logic [CITY_W-1:0]     c2_q;
	logic                  last_q;

	logic          walk_issue;
	logic          emit_issue;
	logic          adv_out;
	logic          emit_done;
	logic          take1;
	logic          take2;
	logic [CW-1:0] room;
	logic [CW-1:0] tail_idx;
	logic [AW-1:0] rd_idx;

	assign room       = n_q - cut_q;
	assign tail_idx   = idx_q - cut_q;
	assign rd_idx     = idx_q[AW-1:0];
	assign walk_issue = (state_q == ST_WALK) && (idx_q != n_q);
	assign adv_out    = emit_v_s1 && (!out_v_q || children.ready);
	assign emit_issue = (state_q == ST_EMIT) && (idx_q != n_q) && (!emit_v_s1 || adv_out);
	assign emit_done  = (state_q == ST_EMIT) && (idx_q == n_q) && !emit_v_s1;
	assign take1 = walk_v_s1 && !(|(map1_q & city_mask(par_f_s1))) && (cnt1_q < room);
	assign take2 = walk_v_s1 && !(|(map2_q & city_mask(par_m_s1))) && (cnt2_q < room);

	assign job_pop     = (state_q == ST_IDLE) && job_valid;
	assign job_release = emit_done;

	assign children.valid          = out_v_q;
	assign children.child_one_city = c1_q;
	assign children.child_two_city = c2_q;
	assign children.last_position  = last_q;

	// Memories
	always_ff @(posedge clk) begin
		if (par_we) begin
			mother_mem[par_bank][par_idx] <= par_mother;
			father_mem[par_bank][par_idx] <= par_father;
		end
		if (walk_issue || emit_issue) begin
			par_m_s1 <= mother_mem[bank_q][rd_idx];
			par_f_s1 <= father_mem[bank_q][rd_idx];
		end
		if (take1) begin
			tail1_mem[cnt1_q[AW-1:0]] <= par_f_s1;
		end
		if (take2) begin
			tail2_mem[cnt2_q[AW-1:0]] <= par_m_s1;
		end
		if (emit_issue) begin
			tail1_s1 <= tail1_mem[tail_idx[AW-1:0]];
			tail2_s1 <= tail2_mem[tail_idx[AW-1:0]];
		end
	end

	// Job fields and emission payload
	always_ff @(posedge clk) begin
		if (job_pop) begin
			{bank_q, n_q, cut_q, map1_q, map2_q} <= job_data;
		end
		if (emit_issue) begin
			emit_pre_s1  <= idx_q < cut_q;
			emit_ok1_s1  <= tail_idx < cnt1_q;
			emit_ok2_s1  <= tail_idx < cnt2_q;
			emit_last_s1 <= (idx_q + CW'(1)) == n_q;
		end
		if (adv_out) begin
			c1_q   <= emit_pre_s1 ? par_m_s1 : (emit_ok1_s1 ? tail1_s1 : '0);
			c2_q   <= emit_pre_s1 ? par_f_s1 : (emit_ok2_s1 ? tail2_s1 : '0);
			last_q <= emit_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			cnt1_q       <= '0;
			cnt2_q       <= '0;
			walk_v_s1    <= 1'b0;
			walk_last_s1 <= 1'b0;
			emit_v_s1    <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_WALK;
						idx_q   <= '0;
						cnt1_q  <= '0;
						cnt2_q  <= '0;
					end
				end
				ST_WALK: begin
					if (walk_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (walk_v_s1 && walk_last_s1) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end
					if (take1) begin
						cnt1_q <= cnt1_q + CW'(1);
					end
					if (take2) begin
						cnt2_q <= cnt2_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			walk_v_s1    <= walk_issue;
			walk_last_s1 <= walk_issue && ((idx_q + CW'(1)) == n_q);

			if (emit_issue) begin
				emit_v_s1 <= 1'b1;
			end else if (adv_out) begin
				emit_v_s1 <= 1'b0;
			end

			if (adv_out) begin
				out_v_q <= 1'b1;
			end else if (children.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	a_tail_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt1_q <= room && cnt2_q <= room))
		else $error("child tail overruns its room");

	a_walk_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_v_s1 |-> (state_q == ST_WALK))
		else $error("walk data outside walk phase");

	a_emit_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_v_s1 |-> (state_q == ST_EMIT))
		else $error("emission data outside emit phase");

endmodule

[rtl/core/order_crossover_permutation_unit.sv]
// Load: one parent position per cycle while parents.ready is high; ready drops while both banks
// hold pairs not yet emitted. The pair is handed to the back end on the last position.
// The back end walks, then emits each pair; the next pair loads into the other bank meanwhile.
// Reset (arst_n low) clears control, the job queue and the prefix maps, sets city_count to 32;
// parent and child stores keep their contents and are always rewritten before use.
module order_crossover_permutation_unit #(
	parameter int MAX_CITIES = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ocp_in_if.sink                    parents,
	ocp_out_if.source                 children,
	input  logic                      cfg_wr_en,
	input  logic [ocp_pkg::CC_W-1:0]  cfg_wr_data
);
	import ocp_pkg::*;

	localparam int AW    = $clog2(MAX_CITIES);
	localparam int CW    = $clog2(MAX_CITIES + 1);
	localparam int JOB_W = 1 + 2 * CW + 2 * MAX_CITIES;

	// Parent store write port: front end writes the loading bank
	logic              par_we;
	logic              par_bank;
	logic [AW-1:0]     par_idx;
	logic [CITY_W-1:0] par_mother;
	logic [CITY_W-1:0] par_father;

	// Job hand-off: bank, tour length, clamped cut and both prefix maps
	logic             job_push;
	logic [JOB_W-1:0] job_push_data;
	logic             job_pop;
	logic             job_valid;
	logic [JOB_W-1:0] job_pop_data;
	logic             job_release;

	// Front end: accept parent requests, store them, build the prefix maps
	ocp_front #(
		.MAX_CITIES (MAX_CITIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.parents     (parents),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.par_we      (par_we),
		.par_bank    (par_bank),
		.par_idx     (par_idx),
		.par_mother  (par_mother),
		.par_father  (par_father),
		.job_push    (job_push),
		.job_data    (job_push_data),
		.job_release (job_release)
	);

	// Two-entry queue: one entry per parent bank
	ocp_job_fifo #(
		.WIDTH (JOB_W)
	) u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_push_data),
		.pop       (job_pop),
		.not_empty (job_valid),
		.pop_data  (job_pop_data)
	);

	// Back end: walk the other parent, then emit both children with an output register
	ocp_back #(
		.MAX_CITIES (MAX_CITIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.children    (children),
		.par_we      (par_we),
		.par_bank    (par_bank),
		.par_idx     (par_idx),
		.par_mother  (par_mother),
		.par_father  (par_father),
		.job_valid   (job_valid),
		.job_data    (job_pop_data),
		.job_pop     (job_pop),
		.job_release (job_release)
	);

endmodule
